### rtl/core/gcd_pkg.sv
// gcd_pkg: shared types for the greatest common divisor unit.
// Holds the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package gcd_pkg;

   // controller states
   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;     // take a new operand pair
      logic step;     // one binary reduction step
      logic capture;  // move finished divisor into output register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic finished; // one working operand has reached zero
   } status_type;

endpackage

### rtl/core/gcd_req_if.sv
// gcd_req_if: valid/ready channel that carries one operand pair word.
// Width follows OPERAND_BITS. No dependencies.
`timescale 1ns / 1ps

interface gcd_req_if #(
   parameter int OPERAND_BITS = 31
) ();
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] operand_a;
   logic [OPERAND_BITS-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

### rtl/core/gcd_rsp_if.sv
// gcd_rsp_if: valid/ready channel that carries one divisor word.
// Width follows OPERAND_BITS. No dependencies.
`timescale 1ns / 1ps

interface gcd_rsp_if #(
   parameter int OPERAND_BITS = 31
) ();
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] divisor;

   modport source (output valid, output divisor, input ready);
   modport sink   (input valid, input divisor, output ready);
endinterface

### rtl/core/gcd_by_common_prime_factors_unit.sv
// Greatest common divisor unit (binary GCD), top level.
// One operand pair is in the datapath at a time, set by the single
// subtract/shift loop: a new pair is accepted only after the last divisor
// has been captured into the output register. Reset (synchronous, active
// high) clears the controller and output valid.
`timescale 1ns / 1ps

module gcd_by_common_prime_factors_unit #(
   parameter int OPERAND_BITS = 31
) (
   input  logic      clock,
   input  logic      reset,
   gcd_req_if.sink   req,
   gcd_rsp_if.source rsp
);
   gcd_pkg::cmd_type    cmd;
   gcd_pkg::status_type status;

   gcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gcd_dpath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dpath (
      .clock     (clock),
      .operand_a (req.operand_a),
      .operand_b (req.operand_b),
      .cmd       (cmd),
      .status    (status),
      .divisor   (rsp.divisor)
   );

endmodule

### rtl/core/gcd_dpath.sv
// gcd_dpath: binary GCD datapath (working operands, shared power of two,
// output register). Driven by gcd_ctrl through gcd_pkg command/status.
`timescale 1ns / 1ps

module gcd_dpath #(
   parameter int OPERAND_BITS = 31
) (
   input  logic                    clock,
   input  logic [OPERAND_BITS-1:0] operand_a,
   input  logic [OPERAND_BITS-1:0] operand_b,
   input  gcd_pkg::cmd_type        cmd,
   output gcd_pkg::status_type     status,
   output logic [OPERAND_BITS-1:0] divisor
);
   localparam int K_BITS = (OPERAND_BITS > 2) ? $clog2(OPERAND_BITS) : 1;

   logic [OPERAND_BITS-1:0] a_ff, a_in;
   logic [OPERAND_BITS-1:0] b_ff, b_in;
   logic [K_BITS-1:0]       k_ff, k_in;
   logic [OPERAND_BITS-1:0] div_ff, div_in;

   logic                    a_ge_b;
   logic [OPERAND_BITS-1:0] diff;

   // odd/odd case: larger minus smaller, chosen by one comparison
   assign a_ge_b = (a_ff >= b_ff);
   assign diff   = a_ge_b ? (a_ff - b_ff) : (b_ff - a_ff);

   assign status.finished = (a_ff == '0) || (b_ff == '0);

   // reduction step
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (cmd.load) begin
         a_in = operand_a;
         b_in = operand_b;
         k_in = '0;
      end else if (cmd.step) begin
         case ({a_ff[0], b_ff[0]})
            2'b00: begin
               // both even: factor of two is common
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end
            2'b01: a_in = a_ff >> 1;
            2'b10: b_in = b_ff >> 1;
            default: begin
               if (a_ge_b) a_in = diff;
               else        b_in = diff;
            end
         endcase
      end
   end

   // result: the surviving operand times the common power of two
   always_comb begin
      div_in = div_ff;
      if (cmd.capture) div_in = (a_ff | b_ff) << k_ff;
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      div_ff <= div_in;
   end

   assign divisor = div_ff;

endmodule

### rtl/core/gcd_ctrl.sv
// gcd_ctrl: controller for the GCD unit; handshakes and sequencing.
// Uses gcd_pkg state, command and status types.
`timescale 1ns / 1ps

module gcd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  gcd_pkg::status_type status,
   output gcd_pkg::cmd_type    cmd
);
   gcd_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         gcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = gcd_pkg::ST_RUN;
            end
         end
         gcd_pkg::ST_RUN: begin
            if (!status.finished) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               // wait here until the output register can take the word
               cmd.capture = 1'b1;
               state_in    = gcd_pkg::ST_IDLE;
            end
         end
         default: state_in = gcd_pkg::ST_IDLE;
      endcase
   end

   // output word valid
   assign out_valid_in = cmd.capture || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // checks
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!out_valid_ff || rsp_ready))
      else $error("divisor captured over an unaccepted word");

   a_capture_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_valid)
      else $error("captured divisor not presented");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == gcd_pkg::ST_RUN))
      else $error("accepted operands but not running");

   a_no_step_after_finish: assert property (@(posedge clock) disable iff (reset)
      !(cmd.step && status.finished))
      else $error("step issued after reduction finished");

endmodule

### tb/gcd_by_common_prime_factors_unit_test.sv
// Self-checking testbench for gcd_by_common_prime_factors_unit.
// Directed table of operand pairs, then shaped random pairs, checked against typed-in
// values or a Euclid predictor. Needs gcd_req_if and gcd_rsp_if.
`timescale 1ns / 1ps

module gcd_by_common_prime_factors_unit_test;

   localparam int OPERAND_BITS = 31;
   localparam int RANDOM_PAIRS = 1200;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * OPERAND_BITS + 8;
   localparam int NUM_DIRECTED = 21;

   typedef bit [OPERAND_BITS-1:0] operand_type;

   localparam operand_type OPERAND_MAX = '1;

   typedef struct packed {
      operand_type a;
      operand_type b;
   } operand_pair_type;

   // directed row: expected value typed in only when known is set
   typedef struct packed {
      operand_type a;
      operand_type b;
      bit          known;
      operand_type want;
   } directed_row_type;

   typedef struct {
      operand_type a;
      operand_type b;
      operand_type divisor;
   } pending_divisor_type;

   logic clock;
   logic reset;

   gcd_req_if #(.OPERAND_BITS(OPERAND_BITS)) req_bus ();
   gcd_rsp_if #(.OPERAND_BITS(OPERAND_BITS)) rsp_bus ();

   gcd_by_common_prime_factors_unit #(
      .OPERAND_BITS(OPERAND_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   pending_divisor_type pending_divisors[$];
   directed_row_type    directed_rows[NUM_DIRECTED];
   int                  failures      = 0;
   int                  checked_words = 0;
   int                  cycle_count   = 0;
   bit                  steady        = 1'b0;  // no idling on either side while set

   // Euclid's remainder loop
   function automatic operand_type common_divisor(operand_type x, operand_type y);
      operand_type r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // random value of the given width, never zero
   function automatic operand_type nonzero_value(int unsigned width);
      longint unsigned v;
      v = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
      if (v == 0)
         v = 1;
      return operand_type'(v);
   endfunction

   // mostly pairs with structure (shared factor, divisibility, powers of two)
   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      int unsigned      w;
      longint unsigned  g;
      operand_type      t;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            p.a = nonzero_value(OPERAND_BITS);
            p.b = nonzero_value(OPERAND_BITS);
         end
         3, 4, 5: begin
            w   = $urandom_range(1, 20);
            g   = 64'(nonzero_value(w));
            p.a = operand_type'(g * 64'(nonzero_value(OPERAND_BITS - w)));
            p.b = operand_type'(g * 64'(nonzero_value(OPERAND_BITS - w)));
         end
         6: begin
            w   = $urandom_range(1, OPERAND_BITS - 1);
            p.a = nonzero_value(w);
            p.b = operand_type'(64'(p.a) * 64'(nonzero_value(OPERAND_BITS - w)));
            if ($urandom_range(0, 1)) begin
               t   = p.a;
               p.a = p.b;
               p.b = t;
            end
         end
         7: begin
            p.a = nonzero_value(8) << $urandom_range(0, OPERAND_BITS - 8);
            p.b = nonzero_value(8) << $urandom_range(0, OPERAND_BITS - 8);
         end
         8: begin
            p.a = nonzero_value($urandom_range(1, OPERAND_BITS));
            p.b = p.a;
         end
         default: begin
            p.a = operand_type'($urandom_range(1, 255));
            p.b = operand_type'($urandom_range(1, 255));
         end
      endcase
      return p;
   endfunction

   // drive one operand word and log its expected divisor on acceptance
   task automatic send_pair(operand_pair_type p, bit known, operand_type want);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operand_a <= p.a;
      req_bus.operand_b <= p.b;
      do @(posedge clock); while (!req_bus.ready);
      pending_divisors.push_back('{p.a, p.b,
                                   known ? want : common_divisor(p.a, p.b)});
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d divisor words outstanding",
                  $time, cycle_count, pending_divisors.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stalls, check each word against the oldest expectation
   initial begin
      pending_divisor_type exp;
      int                  gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         checked_words++;
         if (pending_divisors.size() == 0) begin
            failures++;
            $display("%0t: unexpected divisor word: expected none, actual %0d",
                     $time, rsp_bus.divisor);
         end else begin
            exp = pending_divisors.pop_front();
            if (rsp_bus.divisor !== exp.divisor) begin
               failures++;
               $display("%0t: divisor of %0d and %0d: expected %0d, actual %0d",
                        $time, exp.a, exp.b, exp.divisor, rsp_bus.divisor);
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      operand_pair_type p;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      rsp_bus.ready     <= 1'b0;

      // extremes, powers of two, alternating bit patterns, worst case for Euclid
      directed_rows[0]  = '{31'd1, 31'd1, 1'b1, 31'd1};
      directed_rows[1]  = '{OPERAND_MAX, OPERAND_MAX, 1'b1, OPERAND_MAX};
      directed_rows[2]  = '{OPERAND_MAX, 31'd1, 1'b1, 31'd1};
      directed_rows[3]  = '{31'd1, OPERAND_MAX, 1'b1, 31'd1};
      directed_rows[4]  = '{OPERAND_MAX, OPERAND_MAX - 31'd1, 1'b1, 31'd1};
      directed_rows[5]  = '{31'h4000_0000, 31'h4000_0000, 1'b1, 31'h4000_0000};
      directed_rows[6]  = '{31'h4000_0000, 31'd1, 1'b1, 31'd1};
      directed_rows[7]  = '{31'h4000_0000, OPERAND_MAX, 1'b1, 31'd1};
      directed_rows[8]  = '{31'h4000_0000, 31'h2000_0000, 1'b1, 31'h2000_0000};
      directed_rows[9]  = '{31'd12, 31'd18, 1'b0, 31'd0};
      directed_rows[10] = '{31'd18, 31'd12, 1'b0, 31'd0};
      directed_rows[11] = '{31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 31'd0};
      directed_rows[12] = '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, 31'd0};
      directed_rows[13] = '{31'd2147483646, 31'd1073741823, 1'b0, 31'd0};
      directed_rows[14] = '{31'd223092870, 31'd2147483646, 1'b0, 31'd0};
      directed_rows[15] = '{31'd123456789, 31'd123456789, 1'b1, 31'd123456789};
      directed_rows[16] = '{31'd1000, 31'd1000000, 1'b0, 31'd0};
      directed_rows[17] = '{31'd1134903170, 31'd1836311903, 1'b0, 31'd0};
      directed_rows[18] = '{31'd2, 31'd3, 1'b1, 31'd1};
      directed_rows[19] = '{31'h7FFF_0000, 31'h0000_FFFF, 1'b0, 31'd0};
      directed_rows[20] = '{31'h7FFF_FFFE, 31'h4000_0000, 1'b0, 31'd0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_pair('{directed_rows[i].a, directed_rows[i].b},
                   directed_rows[i].known, directed_rows[i].want);

      // random part, with periodic stretches of back-to-back traffic
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         steady = (i % 300) < 60;
         p = random_pair();
         send_pair(p, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
      steady = 1'b0;

      while (pending_divisors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d directed and %0d random operand pairs, %0d words checked,",
               NUM_DIRECTED, RANDOM_PAIRS, checked_words);
      $display("with random stalls on both channels and gap-free bursts; %0d failures.",
               failures);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
